// File: hdl/rss_pkg.sv
// rss_pkg: shared types, constants and helpers of the ramp slot sweeper
// used by ramp_slot_sweeper; no dependencies
package rss_pkg;

   localparam int NUM_SLOTS_DEF = 64;
   localparam int DATA_W        = 32;
   localparam int PERIOD_W      = 16;
   localparam int INDEX_W       = 6;
   localparam int REMAIN_W      = 7;

   localparam logic OP_START = 1'b0;
   localparam logic OP_SWEEP = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] step;
      logic signed [DATA_W-1:0] base;
      logic signed [DATA_W-1:0] limit;
      logic signed [DATA_W-1:0] accum;
      logic [PERIOD_W-1:0]      period;
      logic [PERIOD_W-1:0]      counter;
   } slot_word_type;

   localparam int SLOT_WORD_W = $bits(slot_word_type);

   // saturating signed add, clamps to the 32-bit range
   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

// File: hdl/rss_ram.sv
// rss_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module rss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ramp_slot_sweeper.sv
// ramp_slot_sweeper: bank of linear ramp slots swept through an ordered active list
// depends on rss_pkg and rss_ram
//
// usage: a transaction is taken at a clock edge with start high and busy low.
// req_opcode start loads slot req_slot_index with step, base, limit and period,
// clears its accumulator and counter and, unless already listed, appends it to
// the active list; it gives no result and leaves busy low.
// req_opcode sweep visits every listed slot in list order, with busy high until
// the last slot has passed stage d; results come from the response registers
// behind stages a to d, one per cycle, the final one marked by rsp_last.
// the rate is one slot per cycle, set by the read of the list memory followed
// by the read and write back of the slot memory in a four stage pipeline.
// a sweep of an empty list gives one result with rsp_list_empty the next cycle
// and leaves busy low.
// each result is on the rsp_ ports for one cycle with rsp_strobe high; the
// receiver cannot stall.
// reset empties the list and clears all active flags; slot and list memories
// are not cleared and need no clearing pass
module ramp_slot_sweeper #(
   parameter int NUM_SLOTS = rss_pkg::NUM_SLOTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_opcode,
   input  logic [rss_pkg::INDEX_W-1:0]            req_slot_index,
   input  logic signed [rss_pkg::DATA_W-1:0]      req_step,
   input  logic signed [rss_pkg::DATA_W-1:0]      req_base,
   input  logic signed [rss_pkg::DATA_W-1:0]      req_limit,
   input  logic [rss_pkg::PERIOD_W-1:0]           req_period,
   output logic                                   rsp_strobe,
   output logic [rss_pkg::INDEX_W-1:0]            rsp_out_slot,
   output logic signed [rss_pkg::DATA_W-1:0]      rsp_value,
   output logic                                   rsp_fired,
   output logic                                   rsp_ended,
   output logic                                   rsp_list_empty,
   output logic [rss_pkg::REMAIN_W-1:0]           rsp_remaining,
   output logic                                   rsp_last
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int IW = (SW + 1 > rss_pkg::INDEX_W) ? SW + 1 : rss_pkg::INDEX_W;

   // control
   logic           run_ff, run_in;
   logic [CW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]  orig_ff, orig_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           active_ff [NUM_SLOTS];
   logic           active_in [NUM_SLOTS];

   // pipeline
   logic           v1_ff, v1_in, last1_ff, last1_in;
   logic           v2_ff, v2_in, last2_ff, last2_in;
   logic [SW-1:0]  id2_ff, id2_in;
   logic           v3_ff, v3_in, last3_ff, last3_in;
   logic [SW-1:0]  id3_ff, id3_in;
   logic           act3_ff, act3_in, fire3_ff, fire3_in;
   logic [rss_pkg::PERIOD_W-1:0]       cnt3_ff, cnt3_in;
   logic signed [rss_pkg::DATA_W-1:0]  acc3_ff, acc3_in;
   rss_pkg::slot_word_type             w3_ff, w3_in;

   // response
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [rss_pkg::INDEX_W-1:0]        rsp_out_slot_ff, rsp_out_slot_in;
   logic signed [rss_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                               rsp_fired_ff, rsp_fired_in;
   logic                               rsp_ended_ff, rsp_ended_in;
   logic                               rsp_list_empty_ff, rsp_list_empty_in;
   logic [rss_pkg::REMAIN_W-1:0]       rsp_remaining_ff, rsp_remaining_in;
   logic                               rsp_last_ff, rsp_last_in;

   // memories
   logic                               list_we;
   logic [SW-1:0]                      list_waddr;
   logic [SW-1:0]                      list_wdata;
   logic [SW-1:0]                      list_rdata;
   logic                               slot_we;
   logic [SW-1:0]                      slot_waddr;
   rss_pkg::slot_word_type             slot_wdata;
   rss_pkg::slot_word_type             slot_rdata;

   logic                               accept;
   logic [IW-1:0]                      req_idx_ext;
   logic [SW-1:0]                      req_idx;
   logic                               start_wr;
   logic [rss_pkg::PERIOD_W:0]         cnt_next;
   logic signed [rss_pkg::DATA_W-1:0]  sum;
   logic                               stop;
   logic                               d_ended;
   logic [CW-1:0]                      count_dec;
   rss_pkg::slot_word_type             wb;

   assign busy        = run_ff | v1_ff | v2_ff | v3_ff;
   assign accept      = start & ~busy;
   assign req_idx_ext = IW'(req_slot_index);
   assign req_idx     = req_idx_ext[SW-1:0];
   assign start_wr    = accept && (req_opcode == rss_pkg::OP_START)
                        && (req_idx_ext < IW'(NUM_SLOTS));

   rss_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_waddr),
      .wr_data (list_wdata),
      .rd_addr (rd_ptr_ff[SW-1:0]),
      .rd_data (list_rdata)
   );

   rss_ram #(.WIDTH(rss_pkg::SLOT_WORD_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (list_rdata),
      .rd_data (slot_rdata)
   );

   always_comb begin
      run_in    = run_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      orig_in   = orig_ff;
      count_in  = count_ff;
      active_in = active_ff;

      list_we    = 1'b0;
      list_waddr = count_ff[SW-1:0];
      list_wdata = req_idx;
      slot_we    = 1'b0;
      slot_waddr = req_idx;
      slot_wdata = '{step: req_step, base: req_base, limit: req_limit, accum: '0,
                     period: req_period, counter: '0};

      rsp_strobe_in     = 1'b0;
      rsp_out_slot_in   = '0;
      rsp_value_in      = '0;
      rsp_fired_in      = 1'b0;
      rsp_ended_in      = 1'b0;
      rsp_list_empty_in = 1'b0;
      rsp_remaining_in  = '0;
      rsp_last_in       = 1'b0;

      // start transaction
      if (start_wr) begin
         slot_we = 1'b1;
         if (!active_ff[req_idx] && (count_ff < CW'(NUM_SLOTS))) begin
            list_we  = 1'b1;
            count_in = count_ff + CW'(1);
         end
         active_in[req_idx] = 1'b1;
      end

      // sweep transaction
      if (accept && (req_opcode == rss_pkg::OP_SWEEP)) begin
         if (count_ff == '0) begin
            rsp_strobe_in     = 1'b1;
            rsp_list_empty_in = 1'b1;
            rsp_last_in       = 1'b1;
         end else begin
            run_in    = 1'b1;
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            orig_in   = count_ff;
         end
      end

      // stage a: list read issue
      v1_in    = run_ff;
      last1_in = run_ff && (rd_ptr_ff == orig_ff - CW'(1));
      if (run_ff) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
         if (last1_in) begin
            run_in = 1'b0;
         end
      end

      // stage b: slot read issue
      v2_in    = v1_ff;
      last2_in = last1_ff;
      id2_in   = list_rdata;

      // stage c: counter and accumulator
      v3_in    = v2_ff;
      last3_in = last2_ff;
      id3_in   = id2_ff;
      act3_in  = active_ff[id2_ff];
      cnt_next = {1'b0, slot_rdata.counter} + (rss_pkg::PERIOD_W+1)'(1);
      fire3_in = cnt_next >= {1'b0, slot_rdata.period};
      cnt3_in  = cnt_next[rss_pkg::PERIOD_W-1:0];
      acc3_in  = rss_pkg::sat_add(slot_rdata.step, slot_rdata.accum);
      w3_in    = slot_rdata;

      // stage d: output value, limit check, write back
      wb        = w3_ff;
      sum       = rss_pkg::sat_add(acc3_ff, w3_ff.base);
      stop      = (w3_ff.step > 0) ? (sum >= w3_ff.limit) : (sum <= w3_ff.limit);
      d_ended   = 1'b0;
      count_dec = count_ff - CW'(1);
      if (v3_ff) begin
         rsp_strobe_in   = 1'b1;
         rsp_out_slot_in = rss_pkg::INDEX_W'(id3_ff);
         rsp_last_in     = last3_ff;
         if (!act3_ff) begin
            d_ended = 1'b1;
         end else if (!fire3_ff) begin
            wb.counter = cnt3_ff;
         end else begin
            rsp_fired_in = 1'b1;
            wb.counter   = '0;
            if (stop) begin
               rsp_value_in      = w3_ff.limit;
               wb.accum          = '0;
               d_ended           = 1'b1;
               active_in[id3_ff] = 1'b0;
            end else begin
               rsp_value_in = sum;
               wb.accum     = acc3_ff;
            end
         end
         slot_we    = act3_ff;
         slot_waddr = id3_ff;
         slot_wdata = wb;
         rsp_ended_in = d_ended;
         if (d_ended) begin
            count_in         = count_dec;
            rsp_remaining_in = rss_pkg::REMAIN_W'(count_dec);
         end else begin
            list_we          = 1'b1;
            list_waddr       = wr_ptr_ff[SW-1:0];
            list_wdata       = id3_ff;
            wr_ptr_in        = wr_ptr_ff + CW'(1);
            rsp_remaining_in = rss_pkg::REMAIN_W'(count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         count_ff      <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         run_ff        <= run_in;
         count_ff      <= count_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         rsp_strobe_ff <= rsp_strobe_in;
         active_ff     <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff         <= rd_ptr_in;
      wr_ptr_ff         <= wr_ptr_in;
      orig_ff           <= orig_in;
      last1_ff          <= last1_in;
      last2_ff          <= last2_in;
      id2_ff            <= id2_in;
      last3_ff          <= last3_in;
      id3_ff            <= id3_in;
      act3_ff           <= act3_in;
      fire3_ff          <= fire3_in;
      cnt3_ff           <= cnt3_in;
      acc3_ff           <= acc3_in;
      w3_ff             <= w3_in;
      rsp_out_slot_ff   <= rsp_out_slot_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_fired_ff      <= rsp_fired_in;
      rsp_ended_ff      <= rsp_ended_in;
      rsp_list_empty_ff <= rsp_list_empty_in;
      rsp_remaining_ff  <= rsp_remaining_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_slot   = rsp_out_slot_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_ended      = rsp_ended_ff;
   assign rsp_list_empty = rsp_list_empty_ff;
   assign rsp_remaining  = rsp_remaining_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
